[rtl/selective_repeat_receiver_macros.svh]
// Assertion macros for the selective repeat receiver checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("selective repeat receiver check failed");

// Next-cycle implication, switched off while reset is high.
`define SRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("selective repeat receiver check failed");

// Next-cycle implication that also holds across reset.
`define SRR_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("selective repeat receiver check failed");

`endif

[rtl/srr_pkg.sv]
// Package of the selective repeat receiver: sizes, result kinds, controller
// states and the command/status structs between controller and datapath.
`default_nettype none

package srr_pkg;

  localparam int SEQ_W        = 4;
  localparam int RING_DEPTH   = 1 << SEQ_W;
  localparam int MAX_WINDOW   = 8;
  localparam int WIN_W        = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int KIND_W       = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND_ACK = 2'd0,
    KIND_DELIVER  = 2'd1,
    KIND_ACK_IN   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_STORE,
    S_SEND_ACK,
    S_ACK_IN,
    S_READ,
    S_DELIVER
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  store;
    logic  clr_cnt;
    logic  deliver;
    logic  load_out;
    kind_t out_kind;
    logic  out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic cap_ok;
    logic cap_is_ack;
    logic in_window;
    logic seq_acked;
    logic base_ready;
    logic next_ready;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/srr_in_if.sv]
// Packet channel of the selective repeat receiver: valid, ready and one
// packet word. Uses the sizes of srr_pkg.
`default_nettype none

interface srr_in_if;
  logic                              valid;
  logic                              ready;
  logic [srr_pkg::SEQ_W-1:0]         seq_number;
  logic                              is_ack;
  logic                              final_chunk;
  logic [srr_pkg::PAYLOAD_BITS-1:0]  payload_word;
  logic                              checksum_ok;

  modport source (output valid, seq_number, is_ack, final_chunk, payload_word,
                  checksum_ok, input ready);
  modport sink (input valid, seq_number, is_ack, final_chunk, payload_word,
                checksum_ok, output ready);
endinterface

`default_nettype wire

[rtl/srr_out_if.sv]
// Result channel of the selective repeat receiver: valid, ready and one
// result word. Uses the sizes of srr_pkg.
`default_nettype none

interface srr_out_if;
  logic                              valid;
  logic                              ready;
  logic [srr_pkg::KIND_W-1:0]        kind;
  logic [srr_pkg::SEQ_W-1:0]         out_seq;
  logic [srr_pkg::PAYLOAD_BITS-1:0]  out_payload;
  logic                              out_final_chunk;
  logic                              last_of_run;

  modport source (output valid, kind, out_seq, out_payload, out_final_chunk,
                  last_of_run, input ready);
  modport sink (input valid, kind, out_seq, out_payload, out_final_chunk,
                last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/srr_datapath.sv]
// Datapath of the selective repeat receiver: window register, packet capture,
// slot marks, slot memory, receive base and the result register.
// Depends on srr_pkg.
`default_nettype none

module srr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              window_we,
  input  logic [srr_pkg::WIN_W-1:0]         window_wdata,
  input  logic [srr_pkg::SEQ_W-1:0]         in_seq,
  input  logic                              in_is_ack,
  input  logic                              in_fin,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0]  in_payload,
  input  logic                              in_ok,
  input  logic                              out_ready,
  input  srr_pkg::dp_cmd_t                  cmd,
  output srr_pkg::dp_status_t               status,
  output logic                              out_valid,
  output logic [srr_pkg::KIND_W-1:0]        out_kind,
  output logic [srr_pkg::SEQ_W-1:0]         out_seq,
  output logic [srr_pkg::PAYLOAD_BITS-1:0]  out_payload,
  output logic                              out_fin,
  output logic                              out_last
);

  logic [srr_pkg::WIN_W-1:0]         window;
  logic [srr_pkg::WIN_W-1:0]         eff_window;
  logic [srr_pkg::SEQ_W-1:0]         cap_seq;
  logic                              cap_is_ack;
  logic                              cap_fin;
  logic [srr_pkg::PAYLOAD_BITS-1:0]  cap_payload;
  logic                              cap_ok;
  logic [srr_pkg::SEQ_W-1:0]         base;
  logic [srr_pkg::SEQ_W-1:0]         base_plus1;
  logic [srr_pkg::SEQ_W-1:0]         seq_dist;
  logic [srr_pkg::RING_DEPTH-1:0]    received;
  logic [srr_pkg::RING_DEPTH-1:0]    acked;
  logic [srr_pkg::CNT_W-1:0]         cnt;
  logic [srr_pkg::PAYLOAD_BITS-1:0]  slot_payload [srr_pkg::RING_DEPTH];
  logic                              slot_final   [srr_pkg::RING_DEPTH];
  logic [srr_pkg::PAYLOAD_BITS-1:0]  rd_payload;
  logic                              rd_final;

  // A register value of zero acts as one; values above the maximum clamp.
  always_comb begin
    if (window == '0) begin
      eff_window = srr_pkg::WIN_W'(1);
    end else if (window > srr_pkg::WIN_W'(srr_pkg::MAX_WINDOW)) begin
      eff_window = srr_pkg::WIN_W'(srr_pkg::MAX_WINDOW);
    end else begin
      eff_window = window;
    end
  end

  // Distance from the base wraps around the ring by the subtraction width.
  assign seq_dist   = cap_seq - base;
  assign base_plus1 = base + srr_pkg::SEQ_W'(1);

  assign status.cap_ok     = cap_ok;
  assign status.cap_is_ack = cap_is_ack;
  assign status.in_window  = ({1'b0, seq_dist} < {1'b0, eff_window});
  assign status.seq_acked  = acked[cap_seq];
  assign status.base_ready = received[base] &&
                             (cnt < srr_pkg::CNT_W'(srr_pkg::MAX_WINDOW));
  assign status.next_ready = received[base_plus1] &&
                             (cnt < srr_pkg::CNT_W'(srr_pkg::MAX_WINDOW - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= srr_pkg::WIN_W'(srr_pkg::MAX_WINDOW);
      base      <= '0;
      received  <= '0;
      acked     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (window_we) begin
        window <= window_wdata;
      end
      if (cmd.store) begin
        received[cap_seq] <= 1'b1;
        acked[cap_seq]    <= 1'b1;
      end
      if (cmd.clr_cnt) begin
        cnt <= '0;
      end
      if (cmd.deliver) begin
        received[base] <= 1'b0;
        acked[base]    <= 1'b0;
        base           <= base_plus1;
        cnt            <= cnt + srr_pkg::CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_seq     <= in_seq;
      cap_is_ack  <= in_is_ack;
      cap_fin     <= in_fin;
      cap_payload <= in_payload;
      cap_ok      <= in_ok;
    end
    if (cmd.store) begin
      slot_payload[cap_seq] <= cap_payload;
      slot_final[cap_seq]   <= cap_fin;
    end
    rd_payload <= slot_payload[base];
    rd_final   <= slot_final[base];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind    <= cmd.out_kind;
      out_last    <= cmd.out_last;
      out_seq     <= cmd.deliver ? base : cap_seq;
      out_payload <= cmd.deliver ? rd_payload : '0;
      out_fin     <= cmd.deliver ? rd_final : 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/srr_ctrl.sv]
// Controller of the selective repeat receiver: sequences capture, store,
// ACK and the delivery run. Depends on srr_pkg.
`default_nettype none

module srr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srr_pkg::dp_status_t  status,
  output srr_pkg::dp_cmd_t     cmd
);

  srr_pkg::state_t state;
  srr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.out_kind = srr_pkg::KIND_SEND_ACK;
    unique case (state)
      srr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = srr_pkg::S_EVAL;
        end
      end
      srr_pkg::S_EVAL: begin
        priority if (!status.cap_ok) begin
          state_next = srr_pkg::S_IDLE;
        end else if (status.cap_is_ack) begin
          state_next = srr_pkg::S_ACK_IN;
        end else if (status.in_window) begin
          state_next = srr_pkg::S_STORE;
        end else begin
          cmd.clr_cnt = 1'b1;
          state_next  = srr_pkg::S_READ;
        end
      end
      srr_pkg::S_STORE: begin
        cmd.store   = 1'b1;
        cmd.clr_cnt = 1'b1;
        // Only the first copy of a chunk in a slot is acknowledged.
        state_next  = status.seq_acked ? srr_pkg::S_READ : srr_pkg::S_SEND_ACK;
      end
      srr_pkg::S_SEND_ACK: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = srr_pkg::KIND_SEND_ACK;
          cmd.out_last = !status.base_ready;
          state_next   = srr_pkg::S_READ;
        end
      end
      srr_pkg::S_ACK_IN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = srr_pkg::KIND_ACK_IN;
          cmd.out_last = 1'b1;
          state_next   = srr_pkg::S_IDLE;
        end
      end
      srr_pkg::S_READ: begin
        // The slot memory read of the base entry lands during this cycle.
        state_next = status.base_ready ? srr_pkg::S_DELIVER : srr_pkg::S_IDLE;
      end
      srr_pkg::S_DELIVER: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.deliver  = 1'b1;
          cmd.out_kind = srr_pkg::KIND_DELIVER;
          cmd.out_last = !status.next_ready;
          state_next   = srr_pkg::S_READ;
        end
      end
      default: begin
        state_next = srr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/selective_repeat_receiver.sv]
// Top level of the selective repeat receiver: joins controller and datapath
// to the packet and result channels. Depends on srr_pkg, srr_in_if, srr_out_if.
//
//   channel    direction  handshake             word
//   packet     in         packet.valid/ready    seq, ack, final, payload, check bit
//   result     out        result.valid/ready    kind, seq, payload, final, last
//   window     in         window_we             window width register
//
// A packet with a failed check is dropped and an ACK packet gives one result. A data
// packet in the window is stored, and a first copy is also acknowledged; every data
// packet then starts a delivery run (one ACK and up to 8 chunks at most).
// The delivery run is set by the one-read-port slot memory: a read, then a load.
// Reset is synchronous and needs no clearing pass; the window returns to 8.
// A result waits in the output register; a stall there holds the run.
`default_nettype none

module selective_repeat_receiver (
  input  logic                       clk,
  input  logic                       rst,
  srr_in_if.sink                     packet,
  srr_out_if.source                  result,
  input  logic                       window_we,
  input  logic [srr_pkg::WIN_W-1:0]  window_wdata
);

  srr_pkg::dp_cmd_t    cmd;
  srr_pkg::dp_status_t status;
  logic                in_ready;

  assign packet.ready = in_ready;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (packet.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  srr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .window_we    (window_we),
    .window_wdata (window_wdata),
    .in_seq       (packet.seq_number),
    .in_is_ack    (packet.is_ack),
    .in_fin       (packet.final_chunk),
    .in_payload   (packet.payload_word),
    .in_ok        (packet.checksum_ok),
    .out_ready    (result.ready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (result.valid),
    .out_kind     (result.kind),
    .out_seq      (result.out_seq),
    .out_payload  (result.out_payload),
    .out_fin      (result.out_final_chunk),
    .out_last     (result.last_of_run)
  );

endmodule

`default_nettype wire

[rtl/srr_checker.sv]
// Port-level checks of the selective repeat receiver and the bind that
// attaches them. Depends on srr_pkg and selective_repeat_receiver_macros.svh.
`default_nettype none
`include "selective_repeat_receiver_macros.svh"

module srr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [srr_pkg::KIND_W-1:0]        res_kind,
  input logic [srr_pkg::SEQ_W-1:0]         res_seq,
  input logic [srr_pkg::PAYLOAD_BITS-1:0]  res_payload,
  input logic                              res_final,
  input logic                              res_last
);

  // A result word that is not taken stays in place.
  `SRR_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_seq) && $stable(res_payload) && $stable(res_final) && $stable(res_last))

  // Reset empties the result register.
  `SRR_ASSERT_ALWAYS_NEXT(a_reset_empties, rst, !res_valid)

  // Only a delivered chunk carries payload and a final mark.
  `SRR_ASSERT_NOW(a_zero_fields, res_valid && (res_kind != srr_pkg::KIND_DELIVER), (res_payload == '0) && !res_final)

  // An arrived ACK is always the only result of its packet.
  `SRR_ASSERT_NOW(a_ack_in_last, res_valid && (res_kind == srr_pkg::KIND_ACK_IN), res_last)

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_kind    (result.kind),
  .res_seq     (result.out_seq),
  .res_payload (result.out_payload),
  .res_final   (result.out_final_chunk),
  .res_last    (result.last_of_run)
);

`default_nettype wire
